@@ sv/mreq_pkg.sv @@
// Shared constants and codes for the multi-ring event queue.
// No dependencies; imported by multi_ring_event_queue_core.
package mreq_pkg;

  localparam int RINGS    = 16;
  localparam int SLOTS    = 16;
  localparam int EV_WORDS = 8;
  localparam int WORD_W   = 16;

  localparam int RIDX_W    = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(2 * SLOTS);
  localparam int EV_W      = EV_WORDS * WORD_W;
  localparam int MEM_DEPTH = RINGS * SLOTS;
  localparam int ADDR_W    = RIDX_W + SLOT_W;

  localparam logic [CNT_W-1:0] CNT_TOP   = CNT_W'(2 * SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);
  localparam logic [CNT_W:0]   CNT_SPAN  = (CNT_W + 1)'(2 * SLOTS);

  localparam logic [2:0] ACT_PUT      = 3'd0;
  localparam logic [2:0] ACT_GET      = 3'd1;
  localparam logic [2:0] ACT_TAKE_OVF = 3'd2;
  localparam logic [2:0] ACT_RESET    = 3'd3;
  localparam logic [2:0] ACT_ARM      = 3'd4;
  localparam logic [2:0] ACT_CLR_WAIT = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  // Next counter value, wrapping at twice the ring depth.
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_TOP) ? '0 : c + CNT_W'(1);
  endfunction

  // Slot addressed by a counter: counter modulo SLOTS (counter < 2*SLOTS).
  function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] s;
    s = (c >= CNT_SLOTS) ? c - CNT_SLOTS : c;
    return s[SLOT_W-1:0];
  endfunction

  // Fill level of a ring from its two counters.
  function automatic logic [CNT_W-1:0] occupancy(input logic [CNT_W-1:0] wc,
                                                 input logic [CNT_W-1:0] rc);
    logic [CNT_W:0] d;
    d = (wc >= rc) ? {1'b0, wc} - {1'b0, rc} : {1'b0, wc} + CNT_SPAN - {1'b0, rc};
    return d[CNT_W-1:0];
  endfunction

endpackage

@@ sv/multi_ring_event_queue_core.sv @@
// Top level of the multi-ring event queue: counters, flags and event memory.
// Depends on mreq_pkg.
//
// A bank of RINGS event rings, each holding up to SLOTS events of eight 16-bit
// words. Every accepted input word carries one action on one ring (put, get,
// take overflow, reset, arm wait, clear wait) or a reset of all rings, and
// yields exactly one result word. Per-ring write and read counters, the sticky
// overflow flag and the waiter flag sit in flip-flops cleared by rst; the
// events themselves live in a single-port synchronous RAM of RINGS*SLOTS
// entries, 128 bits wide, with a registered read, and are not cleared by
// reset (a get only ever reads slots that a put has filled). Every action
// but a successful get loads its result straight into the output register;
// a successful get reads the RAM into rd_data and passes through S_READ
// first. A new word is taken in S_IDLE while the output register is empty or
// is being drained in the same cycle; a result held by out_ready low stalls
// the input side. There is no clearing pass; the block is ready once rst falls.
module multi_ring_event_queue_core
  import mreq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [3:0]  ring,
  input  logic        all_rings,
  input  logic [15:0] in_word0,
  input  logic [15:0] in_word1,
  input  logic [15:0] in_word2,
  input  logic [15:0] in_word3,
  input  logic [15:0] in_word4,
  input  logic [15:0] in_word5,
  input  logic [15:0] in_word6,
  input  logic [15:0] in_word7,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        result_flag,
  output logic        wake,
  output logic [15:0] out_word0,
  output logic [15:0] out_word1,
  output logic [15:0] out_word2,
  output logic [15:0] out_word3,
  output logic [15:0] out_word4,
  output logic [15:0] out_word5,
  output logic [15:0] out_word6,
  output logic [15:0] out_word7
);

  // Per-ring control state
  logic [CNT_W-1:0] wcount [RINGS];
  logic [CNT_W-1:0] rcount [RINGS];
  logic [RINGS-1:0] ovf;
  logic [RINGS-1:0] waiter;

  // Event memory
  logic [EV_W-1:0]   mem [MEM_DEPTH];
  logic [EV_W-1:0]   rd_data;
  logic [ADDR_W-1:0] mem_addr;

  state_t state;
  logic   accept;

  // Decode of the current word
  logic              ring_ok;
  logic [RIDX_W-1:0] ridx;
  logic [CNT_W-1:0]  wc, rc, occ;
  logic              full, empty;
  logic              do_put, do_get;
  logic              res_status, res_flag, res_wake;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ring_ok    = (int'(ring) < RINGS);
    ridx       = RIDX_W'(ring);
    wc         = wcount[ridx];
    rc         = rcount[ridx];
    occ        = occupancy(wc, rc);
    full       = (occ >= CNT_SLOTS);
    empty      = (occ == '0);
    do_put     = 1'b0;
    do_get     = 1'b0;
    res_status = 1'b0;
    res_flag   = 1'b0;
    res_wake   = 1'b0;
    mem_addr   = {ridx, slot_of(wc)};
    if (action == ACT_RESET && all_rings) begin
      res_status = 1'b0;
    end else if (action > ACT_CLR_WAIT) begin
      res_status = 1'b0;
    end else if (!ring_ok) begin
      res_status = 1'b1;
    end else begin
      case (action)
        ACT_PUT: begin
          if (full) begin
            res_status = 1'b1;
          end else begin
            do_put   = 1'b1;
            res_wake = waiter[ridx];
          end
        end
        ACT_GET: begin
          if (empty) begin
            res_status = 1'b1;
          end else begin
            do_get   = 1'b1;
            mem_addr = {ridx, slot_of(rc)};
          end
        end
        ACT_TAKE_OVF: res_flag   = ovf[ridx];
        ACT_ARM:      res_status = !empty;
        default:      res_status = 1'b0;
      endcase
    end
  end

  // Control state: counters, flags, sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ovf       <= '0;
      waiter    <= '0;
      for (int i = 0; i < RINGS; i++) begin
        wcount[i] <= '0;
        rcount[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          // raise valid for any result but a successful get's, else drop it once drained
          if (accept && !do_get) begin
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (accept) begin
            // a successful get waits in S_READ for the RAM read
            if (do_get) begin
              state <= S_READ;
            end
            if (action == ACT_RESET && all_rings) begin
              ovf    <= '0;
              waiter <= '0;
              for (int i = 0; i < RINGS; i++) begin
                wcount[i] <= '0;
                rcount[i] <= '0;
              end
            end else if (ring_ok) begin
              case (action)
                ACT_PUT: begin
                  if (full) begin
                    ovf[ridx] <= 1'b1;
                  end else begin
                    wcount[ridx] <= bump(wc);
                  end
                end
                ACT_GET: begin
                  if (!empty) begin
                    rcount[ridx] <= bump(rc);
                  end
                end
                ACT_TAKE_OVF: ovf[ridx] <= 1'b0;
                ACT_RESET: begin
                  wcount[ridx] <= '0;
                  rcount[ridx] <= '0;
                  ovf[ridx]    <= 1'b0;
                  waiter[ridx] <= 1'b0;
                end
                ACT_ARM: begin
                  if (empty) begin
                    waiter[ridx] <= 1'b1;
                  end
                end
                ACT_CLR_WAIT: waiter[ridx] <= 1'b0;
                default: ;
              endcase
            end
          end
        end
        S_READ: begin
          // output register is empty here: entry to this state required it
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Event RAM: one port, write on put, registered read on get
  always_ff @(posedge clk) begin
    if (accept && do_put) begin
      mem[mem_addr] <= {in_word7, in_word6, in_word5, in_word4,
                        in_word3, in_word2, in_word1, in_word0};
    end else if (accept && do_get) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      status      <= 1'b0;
      result_flag <= 1'b0;
      wake        <= 1'b0;
      out_word0   <= rd_data[0*WORD_W +: WORD_W];
      out_word1   <= rd_data[1*WORD_W +: WORD_W];
      out_word2   <= rd_data[2*WORD_W +: WORD_W];
      out_word3   <= rd_data[3*WORD_W +: WORD_W];
      out_word4   <= rd_data[4*WORD_W +: WORD_W];
      out_word5   <= rd_data[5*WORD_W +: WORD_W];
      out_word6   <= rd_data[6*WORD_W +: WORD_W];
      out_word7   <= rd_data[7*WORD_W +: WORD_W];
    end else if (accept && !do_get) begin
      status      <= res_status;
      result_flag <= res_flag;
      wake        <= res_wake;
      out_word0   <= '0;
      out_word1   <= '0;
      out_word2   <= '0;
      out_word3   <= '0;
      out_word4   <= '0;
      out_word5   <= '0;
      out_word6   <= '0;
      out_word7   <= '0;
    end
  end

endmodule
